// ===== sv/isdu_segment_transport_unit_assert.svh =====
// Assertion macros for the segment transport unit.
`ifndef ISDU_SEGMENT_TRANSPORT_UNIT_ASSERT_SVH
`define ISDU_SEGMENT_TRANSPORT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ISDU_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("label");
`define ISDU_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("label");
`else
`define ISDU_ASSERT_CLK(label, clk, rst, prop)
`define ISDU_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== sv/isdu_pkg.sv =====
`timescale 1ns / 1ps
package isdu_pkg;
   localparam int RespDepth = 64;
   localparam int RespAw = $clog2(RespDepth);

   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_LOAD    = 2'd1,
      OP_COMMIT  = 2'd2,
      OP_FETCH   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_IGNORED  = 3'd1,
      ST_SEQ      = 3'd2,
      ST_SERVICE  = 3'd3,
      ST_BUSY     = 3'd4,
      ST_COMPLETE = 3'd5,
      ST_OVERFLOW = 3'd6,
      ST_NOTHING  = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      REG_READ_SVC  = 2'd0,
      REG_WRITE_SVC = 2'd1,
      REG_BUSY_ERR  = 2'd2,
      REG_SVC_ERR   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] byte_in;
   } item_type;

   typedef struct packed {
      logic [7:0]  req_length;
      logic [7:0]  req_subindex;
      logic [15:0] req_index;
      logic        req_is_write;
      logic [7:0]  data_position;
      logic        data_valid;
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [2:0]  status;
   } result_type;

   typedef struct packed {
      logic [3:0] read_svc;
      logic [3:0] write_svc;
      logic [7:0] busy_err;
      logic [7:0] svc_err;
   } cfg_type;
endpackage

// ===== sv/isdu_front.sv =====
`timescale 1ns / 1ps
module isdu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_opcode,
   input  logic [7:0]        in_byte,
   output logic              q_valid,
   input  logic              q_ready,
   output isdu_pkg::item_type q_item
);
   // two-entry queue between intake and execution
   isdu_pkg::item_type mem_ff [2];
   logic               wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= '{opcode: in_opcode, byte_in: in_byte};
      end
   end

`include "isdu_segment_transport_unit_assert.svh"
   `ISDU_ASSERT_NEVER(a_q_over, clock, reset, cnt_ff == 2'd3)
   `ISDU_ASSERT_CLK(a_q_cnt, clock, reset, (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
   `ISDU_ASSERT_CLK(a_q_drain, clock, reset, (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1)
endmodule

// ===== sv/isdu_back.sv =====
`timescale 1ns / 1ps
module isdu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  isdu_pkg::item_type q_item,
   input  isdu_pkg::cfg_type  cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output isdu_pkg::result_type out_data
);
   typedef enum logic [3:0] {
      PH_IDLE = 4'd0, PH_HDR = 4'd1, PH_EXTLEN = 4'd2, PH_IDXHI = 4'd3,
      PH_IDXLO = 4'd4, PH_SUB = 4'd5, PH_DATA = 4'd6, PH_SEG = 4'd7,
      PH_EXEC = 4'd8, PH_RESP = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in, resume_ff, resume_in;
   logic        seg_ff, seg_in, wr_ff, wr_in, ctl_ff, ctl_in;
   logic [5:0]  seq_ff, seq_in;
   logic [15:0] idx_ff, idx_in;
   logic [7:0]  sub_ff, sub_in, len_ff, len_in, pcnt_ff, pcnt_in;
   logic [7:0]  rlen_ff, rlen_in, rpos_ff, rpos_in;
   logic [7:0]  store [isdu_pkg::RespDepth];
   logic        wr_en;
   logic [isdu_pkg::RespAw-1:0] wr_addr;
   logic [7:0]  wr_data;
   logic [isdu_pkg::RespAw-1:0] rd_addr;
   logic [7:0]  rd_ff;
   logic        ov_ff;
   isdu_pkg::result_type res, out_ff;
   logic        fire;
   logic [7:0]  b;
   logic [7:0]  pos1;
   logic        err_ff, err_in;
   logic [7:0]  ecode_ff, ecode_in;

   assign q_ready   = !ov_ff || out_ready;
   assign fire      = q_valid && q_ready;
   assign out_valid = ov_ff;
   assign out_data  = out_ff;
   assign b         = q_item.byte_in;
   assign pos1      = rpos_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff; resume_in = resume_ff; seg_in = seg_ff; wr_in = wr_ff;
      ctl_in = ctl_ff; seq_in = seq_ff; idx_in = idx_ff; sub_in = sub_ff;
      len_in = len_ff; pcnt_in = pcnt_ff; rlen_in = rlen_ff; rpos_in = rpos_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = b;
      res = '0;
      res.status = isdu_pkg::ST_OK;
      unique case (isdu_pkg::opcode_type'(q_item.opcode))
         isdu_pkg::OP_RECEIVE: begin
            if (phase_ff == PH_SEG) begin
               if (b[7]) begin
                  res.status = isdu_pkg::ST_BUSY;
                  phase_in = PH_EXEC;
               end else if (b[5:0] != seq_ff + 6'd1) begin
                  phase_in = PH_IDLE;
                  res.status = isdu_pkg::ST_SEQ;
               end else begin
                  seq_in = b[5:0]; seg_in = !b[6]; phase_in = resume_ff;
               end
            end else if (phase_ff == PH_RESP && !b[7]) begin
               res.status = isdu_pkg::ST_OK;
            end else begin
               unique case (phase_ff)
                  PH_HDR: begin
                     if (b[7:4] == cfg.read_svc) begin
                        wr_in = 1'b0; len_in = '0; pcnt_in = '0;
                        resume_in = PH_IDXHI; phase_in = seg_ff ? PH_SEG : PH_IDXHI;
                     end else if (b[7:4] == cfg.write_svc) begin
                        wr_in = 1'b1; pcnt_in = '0;
                        if (b[3:0] == 4'hF) begin
                           resume_in = PH_EXTLEN; phase_in = seg_ff ? PH_SEG : PH_EXTLEN;
                        end else begin
                           len_in = {4'd0, b[3:0]};
                           resume_in = PH_IDXHI; phase_in = seg_ff ? PH_SEG : PH_IDXHI;
                        end
                     end else begin
                        res.status = isdu_pkg::ST_SERVICE;
                        phase_in = PH_EXEC;
                     end
                  end
                  PH_EXTLEN: begin
                     len_in = b; resume_in = PH_IDXHI; phase_in = seg_ff ? PH_SEG : PH_IDXHI;
                  end
                  PH_IDXHI: begin
                     idx_in = {b, 8'd0}; resume_in = PH_IDXLO;
                     phase_in = seg_ff ? PH_SEG : PH_IDXLO;
                  end
                  PH_IDXLO: begin
                     idx_in = idx_ff | {8'd0, b}; resume_in = PH_SUB;
                     phase_in = seg_ff ? PH_SEG : PH_SUB;
                  end
                  PH_SUB: begin
                     sub_in = b;
                     if (!wr_ff) begin
                        phase_in = PH_EXEC; res.status = isdu_pkg::ST_COMPLETE;
                     end else begin
                        resume_in = PH_DATA; phase_in = seg_ff ? PH_SEG : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     res.data_valid = 1'b1; res.data_position = pcnt_ff;
                     pcnt_in = pcnt_ff + 8'd1;
                     if (pcnt_ff + 8'd1 >= len_ff) begin
                        phase_in = PH_EXEC; res.status = isdu_pkg::ST_COMPLETE;
                     end else begin
                        resume_in = PH_DATA; phase_in = seg_ff ? PH_SEG : PH_DATA;
                     end
                  end
                  PH_EXEC: res.status = isdu_pkg::ST_OK;
                  default: begin
                     if (!b[7]) begin
                        phase_in = PH_IDLE; res.status = isdu_pkg::ST_IGNORED;
                     end else begin
                        seg_in = !b[6]; seq_in = b[5:0]; ctl_in = 1'b0;
                        pcnt_in = '0; rlen_in = '0; rpos_in = '0; phase_in = PH_HDR;
                     end
                  end
               endcase
            end
            // error responses: reuse EXEC marker above, then overwrite to RESP
            if (res.status == isdu_pkg::ST_BUSY || res.status == isdu_pkg::ST_SERVICE) begin
               rlen_in = 8'd2; rpos_in = '0; ctl_in = 1'b0; phase_in = PH_RESP;
            end
         end
         isdu_pkg::OP_LOAD: begin
            if (phase_ff == PH_EXEC && rlen_ff < 8'(isdu_pkg::RespDepth)) begin
               wr_en = 1'b1; wr_addr = rlen_ff[isdu_pkg::RespAw-1:0];
               rlen_in = rlen_ff + 8'd1;
            end else begin
               res.status = isdu_pkg::ST_OVERFLOW;
            end
         end
         isdu_pkg::OP_COMMIT: begin
            if (phase_ff == PH_EXEC) begin
               rpos_in = '0; seq_in = '0; ctl_in = 1'b0; phase_in = PH_RESP;
            end
         end
         isdu_pkg::OP_FETCH: begin
            if (phase_ff != PH_RESP) begin
               res.status = isdu_pkg::ST_NOTHING;
            end else if (!ctl_ff) begin
               res.tx_valid = 1'b1;
               res.tx_byte = {rpos_ff == 8'd0, pos1 >= rlen_ff, seq_ff};
               ctl_in = 1'b1;
            end else if (rpos_ff < rlen_ff) begin
               res.tx_valid = 1'b1;
               if (err_ff && rpos_ff == 8'd0) begin
                  res.tx_byte = 8'h80;
               end else if (err_ff && rpos_ff == 8'd1) begin
                  res.tx_byte = ecode_ff;
               end else begin
                  res.tx_byte = rd_ff;
               end
               rpos_in = pos1;
               if (pos1 >= rlen_ff) begin
                  phase_in = PH_IDLE;
               end else begin
                  ctl_in = 1'b0; seq_in = seq_ff + 6'd1;
               end
            end else begin
               phase_in = PH_IDLE; res.status = isdu_pkg::ST_NOTHING;
            end
         end
         default: ;
      endcase
      res.req_is_write = wr_in;
      res.req_index    = idx_in;
      res.req_subindex = sub_in;
      res.req_length   = len_in;
   end

   // error flag and code override the first two store entries
   always_comb begin
      err_in = err_ff; ecode_in = ecode_ff;
      if (fire && q_item.opcode == isdu_pkg::OP_RECEIVE &&
          (res.status == isdu_pkg::ST_BUSY || res.status == isdu_pkg::ST_SERVICE)) begin
         err_in = 1'b1;
         ecode_in = (res.status == isdu_pkg::ST_BUSY) ? cfg.busy_err : cfg.svc_err;
      end else if (fire && phase_in == PH_HDR) begin
         err_in = 1'b0;
      end
   end

   // hold the entry at the current read position in a register
   assign rd_addr = fire ? rpos_in[isdu_pkg::RespAw-1:0] : rpos_ff[isdu_pkg::RespAw-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; resume_ff <= PH_IDLE; seg_ff <= 1'b0; wr_ff <= 1'b0;
         ctl_ff <= 1'b0; seq_ff <= '0; idx_ff <= '0; sub_ff <= '0; len_ff <= '0;
         pcnt_ff <= '0; rlen_ff <= '0; rpos_ff <= '0; ov_ff <= 1'b0;
         err_ff <= 1'b0; ecode_ff <= '0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in; resume_ff <= resume_in; seg_ff <= seg_in;
            wr_ff <= wr_in; ctl_ff <= ctl_in; seq_ff <= seq_in; idx_ff <= idx_in;
            sub_ff <= sub_in; len_ff <= len_in; pcnt_ff <= pcnt_in;
            rlen_ff <= rlen_in; rpos_ff <= rpos_in;
            err_ff <= err_in; ecode_ff <= ecode_in;
         end
         if (fire) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (fire) out_ff <= res;
      if (fire && wr_en) store[wr_addr] <= wr_data;
      rd_ff <= store[rd_addr];
   end

`include "isdu_segment_transport_unit_assert.svh"
   `ISDU_ASSERT_CLK(a_out_hold, clock, reset, (ov_ff && !out_ready) |=> ov_ff && $stable(out_ff))
   `ISDU_ASSERT_NEVER(a_rlen_max, clock, reset, rlen_ff > 8'(isdu_pkg::RespDepth))
   `ISDU_ASSERT_CLK(a_resp_rpos, clock, reset, (phase_ff == PH_RESP) |-> rlen_ff == 8'd0 || rpos_ff < rlen_ff || ctl_ff)
endmodule

// ===== sv/isdu_segment_transport_unit.sv =====
`timescale 1ns / 1ps
// Segment transport unit: takes one transaction per clock (receive, load, commit or
// fetch) while rsp_tready keeps up, and returns exactly one result transaction for
// each. A two-entry input queue feeds the execute stage, whose registered result
// output takes the next transaction in the cycle a waiting result is accepted; a
// result passes through the queue and then the result register. Config registers sit
// on an APB-style port and must be written only while the unit is idle.
module isdu_segment_transport_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[1:0], byte_in[9:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status, tx_valid, tx_byte, data_valid,
                                    // data_position, req_is_write, req_index,
                                    // req_subindex, req_length, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   isdu_pkg::cfg_type    cfg_ff;
   isdu_pkg::item_type   q_item;
   isdu_pkg::result_type res;
   logic q_valid, q_ready;
   isdu_pkg::reg_index_type ridx;

   assign csr_pready = 1'b1;
   assign ridx = isdu_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{read_svc: 4'd11, write_svc: 4'd3, busy_err: 8'd48, svc_err: 8'd17};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (ridx)
            isdu_pkg::REG_READ_SVC:  cfg_ff.read_svc  <= csr_pwdata[3:0];
            isdu_pkg::REG_WRITE_SVC: cfg_ff.write_svc <= csr_pwdata[3:0];
            isdu_pkg::REG_BUSY_ERR:  cfg_ff.busy_err  <= csr_pwdata[7:0];
            isdu_pkg::REG_SVC_ERR:   cfg_ff.svc_err   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         isdu_pkg::REG_READ_SVC:  csr_prdata = {28'd0, cfg_ff.read_svc};
         isdu_pkg::REG_WRITE_SVC: csr_prdata = {28'd0, cfg_ff.write_svc};
         isdu_pkg::REG_BUSY_ERR:  csr_prdata = {24'd0, cfg_ff.busy_err};
         isdu_pkg::REG_SVC_ERR:   csr_prdata = {24'd0, cfg_ff.svc_err};
         default:                 csr_prdata = '0;
      endcase
   end

   isdu_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_opcode(req_tdata[1:0]), .in_byte(req_tdata[9:2]),
      .q_valid, .q_ready, .q_item
   );

   isdu_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item, .cfg(cfg_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {2'b00, res};
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   typedef enum logic [3:0] {
      PH_IDLE, PH_HDR, PH_EXTLEN, PH_IDXHI, PH_IDXLO, PH_SUB, PH_DATA, PH_SEG, PH_EXEC, PH_RESP
   } phase_type;

   typedef struct {
      isdu_pkg::opcode_type op;
      logic [7:0]           data;
      bit                   typed;
      isdu_pkg::status_type status;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   isdu_segment_transport_unit u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow of the block
   isdu_pkg::cfg_type cfg;
   phase_type  phase, resume_phase;
   logic       seg_flag, wr_flag, ctrl_sent;
   logic [5:0] seq_num;
   logic [15:0] idx_q;
   logic [7:0] sub_q, len_q, pay_cnt, resp_len, resp_pos;
   logic [7:0] resp_mem [isdu_pkg::RespDepth];

   isdu_pkg::result_type expected_q [$];
   int errors = 0;
   int items = 0;
   int requests = 0;
   int results = 0;
   int status_seen [8];
   bit quiet = 0;
   bit start_hold = 0;
   int hold_left = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic void shadow_reset();
      cfg = '{read_svc: 4'd11, write_svc: 4'd3, busy_err: 8'd48, svc_err: 8'd17};
      phase = PH_IDLE;
      resume_phase = PH_IDLE;
      seg_flag = 1'b0;
      wr_flag = 1'b0;
      ctrl_sent = 1'b0;
      seq_num = '0;
      idx_q = '0;
      sub_q = '0;
      len_q = '0;
      pay_cnt = '0;
      resp_len = '0;
      resp_pos = '0;
   endfunction

   function automatic void raise_error(logic [7:0] code);
      resp_mem[0] = 8'h80;
      resp_mem[1] = code;
      resp_len = 8'd2;
      resp_pos = '0;
      ctrl_sent = 1'b0;
      phase = PH_RESP;
   endfunction

   function automatic void step_to(phase_type nxt);
      resume_phase = nxt;
      phase = seg_flag ? PH_SEG : nxt;
   endfunction

   function automatic isdu_pkg::status_type open_request(logic [7:0] b);
      if (!b[7]) return isdu_pkg::ST_IGNORED;
      seg_flag = !b[6];
      seq_num = b[5:0];
      ctrl_sent = 1'b0;
      pay_cnt = '0;
      resp_len = '0;
      resp_pos = '0;
      phase = PH_HDR;
      return isdu_pkg::ST_OK;
   endfunction

   function automatic isdu_pkg::status_type take_byte(logic [7:0] b,
                                                       ref isdu_pkg::result_type r);
      case (phase)
         PH_SEG: begin
            if (b[7]) begin
               raise_error(cfg.busy_err);
               return isdu_pkg::ST_BUSY;
            end
            if (b[5:0] != 6'(seq_num + 6'd1)) begin
               phase = PH_IDLE;
               return isdu_pkg::ST_SEQ;
            end
            seq_num = b[5:0];
            seg_flag = !b[6];
            phase = resume_phase;
            return isdu_pkg::ST_OK;
         end
         PH_RESP: begin
            if (!b[7]) return isdu_pkg::ST_OK;
            phase = PH_IDLE;
            return open_request(b);
         end
         PH_HDR: begin
            if (b[7:4] == cfg.read_svc) begin
               wr_flag = 1'b0;
               len_q = '0;
               pay_cnt = '0;
               step_to(PH_IDXHI);
            end else if (b[7:4] == cfg.write_svc) begin
               wr_flag = 1'b1;
               pay_cnt = '0;
               if (b[3:0] == 4'hF) begin
                  step_to(PH_EXTLEN);
               end else begin
                  len_q = {4'd0, b[3:0]};
                  step_to(PH_IDXHI);
               end
            end else begin
               raise_error(cfg.svc_err);
               return isdu_pkg::ST_SERVICE;
            end
            return isdu_pkg::ST_OK;
         end
         PH_EXTLEN: begin
            len_q = b;
            step_to(PH_IDXHI);
            return isdu_pkg::ST_OK;
         end
         PH_IDXHI: begin
            idx_q = {b, 8'h00};
            step_to(PH_IDXLO);
            return isdu_pkg::ST_OK;
         end
         PH_IDXLO: begin
            idx_q = idx_q | {8'h00, b};
            step_to(PH_SUB);
            return isdu_pkg::ST_OK;
         end
         PH_SUB: begin
            sub_q = b;
            if (!wr_flag) begin
               phase = PH_EXEC;
               return isdu_pkg::ST_COMPLETE;
            end
            step_to(PH_DATA);
            return isdu_pkg::ST_OK;
         end
         PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_position = pay_cnt;
            pay_cnt = pay_cnt + 8'd1;
            if (pay_cnt >= len_q) begin
               phase = PH_EXEC;
               return isdu_pkg::ST_COMPLETE;
            end
            step_to(PH_DATA);
            return isdu_pkg::ST_OK;
         end
         PH_EXEC: return isdu_pkg::ST_OK;
         default: begin
            phase = PH_IDLE;
            return open_request(b);
         end
      endcase
   endfunction

   function automatic isdu_pkg::status_type give_byte(ref isdu_pkg::result_type r);
      logic [7:0] ctrl;
      if (phase != PH_RESP) return isdu_pkg::ST_NOTHING;
      if (!ctrl_sent) begin
         ctrl = {2'b00, seq_num};
         if (resp_pos == 8'd0) ctrl[7] = 1'b1;
         if (8'(resp_pos + 8'd1) >= resp_len) ctrl[6] = 1'b1;
         ctrl_sent = 1'b1;
         r.tx_valid = 1'b1;
         r.tx_byte = ctrl;
         return isdu_pkg::ST_OK;
      end
      if (resp_pos < resp_len) begin
         r.tx_valid = 1'b1;
         r.tx_byte = resp_mem[resp_pos[isdu_pkg::RespAw-1:0]];
         resp_pos = resp_pos + 8'd1;
         if (resp_pos >= resp_len) begin
            phase = PH_IDLE;
         end else begin
            ctrl_sent = 1'b0;
            seq_num = seq_num + 6'd1;
         end
         return isdu_pkg::ST_OK;
      end
      phase = PH_IDLE;
      return isdu_pkg::ST_NOTHING;
   endfunction

   function automatic isdu_pkg::result_type predict_transport(isdu_pkg::opcode_type op,
                                                               logic [7:0] b);
      isdu_pkg::result_type r;
      isdu_pkg::status_type st;
      r = '0;
      st = isdu_pkg::ST_OK;
      case (op)
         isdu_pkg::OP_RECEIVE: st = take_byte(b, r);
         isdu_pkg::OP_LOAD: begin
            if (phase == PH_EXEC && resp_len < 8'(isdu_pkg::RespDepth)) begin
               resp_mem[resp_len[isdu_pkg::RespAw-1:0]] = b;
               resp_len = resp_len + 8'd1;
            end else begin
               st = isdu_pkg::ST_OVERFLOW;
            end
         end
         isdu_pkg::OP_COMMIT: begin
            if (phase == PH_EXEC) begin
               resp_pos = '0;
               seq_num = '0;
               ctrl_sent = 1'b0;
               phase = PH_RESP;
            end
         end
         default: st = give_byte(r);
      endcase
      r.status = st;
      r.req_is_write = wr_flag;
      r.req_index = idx_q;
      r.req_subindex = sub_q;
      r.req_length = len_q;
      return r;
   endfunction

   task automatic send_item(isdu_pkg::opcode_type op, logic [7:0] b, bit typed = 0,
                            isdu_pkg::status_type typed_status = isdu_pkg::ST_OK);
      isdu_pkg::result_type r;
      if (!quiet && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, b, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_transport(op, b);
      if (typed) r.status = typed_status;
      expected_q.push_back(r);
      items++;
   endtask

   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(isdu_pkg::reg_index_type idx, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         isdu_pkg::REG_READ_SVC:  cfg.read_svc = v[3:0];
         isdu_pkg::REG_WRITE_SVC: cfg.write_svc = v[3:0];
         isdu_pkg::REG_BUSY_ERR:  cfg.busy_err = v[7:0];
         default:                 cfg.svc_err = v[7:0];
      endcase
   endtask

   task automatic set_codes(logic [3:0] rd, logic [3:0] wr, logic [7:0] busy, logic [7:0] svc);
      drain(8);
      csr_write(isdu_pkg::REG_READ_SVC, {28'd0, rd});
      csr_write(isdu_pkg::REG_WRITE_SVC, {28'd0, wr});
      csr_write(isdu_pkg::REG_BUSY_ERR, {24'd0, busy});
      csr_write(isdu_pkg::REG_SVC_ERR, {24'd0, svc});
   endtask

   task automatic run_request();
      logic [7:0] body [$];
      logic [7:0] ctrl;
      logic [5:0] seq;
      int kind, len, nload, segmented;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         body.push_back({cfg.read_svc, 4'($urandom_range(0, 15))});
         len = 0;
      end else if (kind < 9) begin
         if ($urandom_range(0, 4) != 0) begin
            len = $urandom_range(0, 14);
            body.push_back({cfg.write_svc, 4'(len)});
         end else begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
            body.push_back({cfg.write_svc, 4'hF});
            body.push_back(8'(len));
         end
      end else begin
         body.push_back(8'($urandom_range(0, 255)));
         len = 0;
      end
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'($urandom_range(0, 255)));
      if (kind >= 4 && kind < 9)
         repeat ((len == 0) ? 1 : len) body.push_back(8'($urandom_range(0, 255)));
      segmented = $urandom_range(0, 1);
      seq = 6'($urandom_range(0, 63));
      requests++;
      if (segmented == 0) send_item(isdu_pkg::OP_RECEIVE, {2'b11, seq});
      foreach (body[i]) begin
         if (segmented != 0) begin
            ctrl = {(i == 0), (i == body.size() - 1), seq};
            if (i != 0 && $urandom_range(0, 99) < 3) ctrl[5:0] = ctrl[5:0] + 6'd7;
            if (i != 0 && $urandom_range(0, 99) < 3) ctrl[7] = 1'b1;
            send_item(isdu_pkg::OP_RECEIVE, ctrl);
            seq = seq + 6'd1;
         end
         send_item(isdu_pkg::OP_RECEIVE, body[i]);
      end
      nload = ($urandom_range(0, 9) == 0) ? 66 : $urandom_range(0, 6);
      repeat (nload) send_item(isdu_pkg::OP_LOAD, 8'($urandom_range(0, 255)));
      send_item(isdu_pkg::OP_COMMIT, 8'($urandom_range(0, 255)));
      repeat (2 * ((nload > isdu_pkg::RespDepth) ? isdu_pkg::RespDepth : nload) +
              $urandom_range(0, 2))
         send_item(isdu_pkg::OP_FETCH, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_random(int count);
      int stop;
      stop = items + count;
      while (items < stop) begin
         if ($urandom_range(0, 3) != 0)
            run_request();
         else
            repeat ($urandom_range(1, 6))
               send_item(isdu_pkg::opcode_type'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      isdu_pkg::result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = isdu_pkg::result_type'(rsp_tdata[53:0]);
         results++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(got.status), 32'd0);
         end else begin
            want = expected_q.pop_front();
            status_seen[got.status]++;
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.tx_valid !== want.tx_valid)
               report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
               report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
            if (got.data_valid !== want.data_valid)
               report_mismatch("data_valid", 32'(got.data_valid), 32'(want.data_valid));
            if (got.data_position !== want.data_position)
               report_mismatch("data_position", 32'(got.data_position),
                               32'(want.data_position));
            if (got.req_is_write !== want.req_is_write)
               report_mismatch("req_is_write", 32'(got.req_is_write), 32'(want.req_is_write));
            if (got.req_index !== want.req_index)
               report_mismatch("req_index", 32'(got.req_index), 32'(want.req_index));
            if (got.req_subindex !== want.req_subindex)
               report_mismatch("req_subindex", 32'(got.req_subindex), 32'(want.req_subindex));
            if (got.req_length !== want.req_length)
               report_mismatch("req_length", 32'(got.req_length), 32'(want.req_length));
         end
      end
      if (start_hold && hold_left == 0) begin
         hold_left = 300;
         start_hold <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || $urandom_range(0, 99) >= 24;
      end
   end

   row_type directed [] = '{
      '{isdu_pkg::OP_FETCH,   8'h00, 1, isdu_pkg::ST_NOTHING},
      '{isdu_pkg::OP_RECEIVE, 8'h00, 1, isdu_pkg::ST_IGNORED},
      '{isdu_pkg::OP_LOAD,    8'hFF, 1, isdu_pkg::ST_OVERFLOW},
      '{isdu_pkg::OP_COMMIT,  8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'hC5, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'hB0, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'hFF, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'hAB, 1, isdu_pkg::ST_COMPLETE},
      '{isdu_pkg::OP_RECEIVE, 8'h12, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_LOAD,    8'h5A, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_LOAD,    8'hFF, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_COMMIT,  8'h00, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_FETCH,   8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_FETCH,   8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h3F, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_FETCH,   8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_FETCH,   8'h00, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_FETCH,   8'h00, 1, isdu_pkg::ST_NOTHING},
      '{isdu_pkg::OP_RECEIVE, 8'h80, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h3F, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h01, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h02, 0, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'hBF, 1, isdu_pkg::ST_BUSY},
      '{isdu_pkg::OP_RECEIVE, 8'hC1, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h75, 1, isdu_pkg::ST_SERVICE},
      '{isdu_pkg::OP_RECEIVE, 8'h80, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h30, 1, isdu_pkg::ST_OK},
      '{isdu_pkg::OP_RECEIVE, 8'h05, 1, isdu_pkg::ST_SEQ}
   };

   initial begin
      shadow_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_item(directed[i].op, directed[i].data, directed[i].typed, directed[i].status);
      run_random(200);
      set_codes(4'd0, 4'd15, 8'd0, 8'd255);
      run_random(200);
      start_hold <= 1'b1;
      run_random(80);
      set_codes(4'd7, 4'd7, 8'd255, 8'd0);
      quiet = 1;
      run_random(180);
      quiet = 0;
      set_codes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(210);
      drain(10);
      $display("sent %0d transactions over %0d requests, checked %0d results, 4 code settings",
               items, requests, results);
      $display("status counts ok..nothing: %0d %0d %0d %0d %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+sv
sv/isdu_pkg.sv
sv/isdu_front.sv
sv/isdu_back.sv
sv/isdu_segment_transport_unit.sv
tb/tb.sv
